// File: rtl/core/subleq_pkg.sv
// ---------------------------------------------------------------------------
// subleq_pkg
// Shared types and constants of the subleq core: state codes, datapath
// selects, and the command and status words between controller and datapath.
// ---------------------------------------------------------------------------
package subleq_pkg;

	localparam int DEFAULT_MEM_DEPTH = 65536;
	localparam int WORD_W            = 32;
	localparam int OPD_W             = 30;
	localparam int PERIOD_W          = 24;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd800000;

	localparam int IRQ_VEC_ADDR = 0;
	localparam int IRQ_RET_ADDR = 1;
	localparam int RTC_SEC_ADDR = 64;
	localparam int RTC_HI_ADDR  = 65;
	localparam int RTC_NS_ADDR  = 66;

	typedef enum logic [1:0] {
		FN_LOAD = 2'd0,
		FN_READ = 2'd1,
		FN_EXEC = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_A,
		OP_B,
		OP_C
	} op_sel_t;

	typedef enum logic [2:0] {
		ASEL_PC,
		ASEL_WRAP,
		ASEL_CLR,
		ASEL_VEC,
		ASEL_RET,
		ASEL_RTC_S,
		ASEL_RTC_H,
		ASEL_RTC_N
	} addr_sel_t;

	typedef enum logic [2:0] {
		WSEL_ZERO,
		WSEL_DATA,
		WSEL_KEY,
		WSEL_SECS,
		WSEL_NSEC,
		WSEL_SUB,
		WSEL_PC4
	} wdata_sel_t;

	typedef enum logic [2:0] {
		WSRC_ADDR,
		WSRC_QRD,
		WSRC_OPA,
		WSRC_OPB,
		WSRC_OPC
	} wrap_src_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_HWRAP,
		S_HWAIT,
		S_HRD,
		S_FETCH,
		S_RAW,
		S_IWAIT,
		S_IND,
		S_DEC,
		S_KWAIT,
		S_SWAIT,
		S_SER,
		S_RTC0,
		S_RTC1,
		S_RTC2,
		S_AWRAP,
		S_AWAIT,
		S_ARD,
		S_BWAIT,
		S_BRD,
		S_BWR,
		S_CWAIT,
		S_M0RD,
		S_M0CHK,
		S_TWAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic       mem_en;
		logic       mem_we;
		addr_sel_t  addr_sel;
		wdata_sel_t wdata_sel;
		logic       wrap_start;
		wrap_src_t  wrap_src;
		logic       pc_inc;
		logic       pc_load;
		logic       op_we;
		op_sel_t    op_sel;
		logic       tmp_we;
		logic       sub_we;
		logic       timer_inc;
		logic       timer_clr;
		logic       clr_inc;
		logic       in_cap;
		logic       out_clr;
		logic       set_rd;
		logic       set_serial;
		logic       set_halt;
		logic       set_tick;
	} cmd_t;

	typedef struct packed {
		logic wrap_done;
		logic raw_ind;
		logic a_m1;
		logic b_m1;
		logic a_rtc;
		logic c_zero;
		logic sub_le0;
		logic vec_nz;
		logic tick_due;
		logic clr_last;
	} stat_t;

endpackage

// File: rtl/core/subleq_wrap.sv
// ---------------------------------------------------------------------------
// subleq_wrap
// Reduces a 32-bit word modulo the memory depth. A power-of-two depth is a
// registered mask; any other depth estimates the quotient with a reciprocal
// multiplication, subtracts quotient times depth and corrects once, in three
// stages.
// ---------------------------------------------------------------------------
module subleq_wrap import subleq_pkg::*; #(
	parameter int MEM_DEPTH = DEFAULT_MEM_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [WORD_W-1:0]            val,
	output logic                         done,
	output logic [$clog2(MEM_DEPTH)-1:0] res
);

	localparam int AW   = $clog2(MEM_DEPTH);
	localparam bit POW2 = (MEM_DEPTH & (MEM_DEPTH - 1)) == 0;

	generate
		if (POW2) begin : g_mask
			logic          done_q;
			logic [AW-1:0] res_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					res_q <= val[AW-1:0];
				end
			end

			assign done = done_q;
			assign res  = res_q;
		end else begin : g_recip
			localparam int MW = WORD_W + 1 - AW;
			localparam logic [MW-1:0] RECIP = MW'((64'd1 << WORD_W) / 64'(MEM_DEPTH));
			localparam logic [AW-1:0] DIV   = AW'(MEM_DEPTH);
			localparam logic [AW:0]   DIV_X = (AW+1)'(MEM_DEPTH);

			logic                 v_s1;
			logic                 v_s2;
			logic                 v_s3;
			logic                 done_q;
			logic [WORD_W-1:0]    x_s1;
			logic [WORD_W-1:0]    x_s2;
			logic [MW-1:0]        q_s2;
			logic [AW:0]          r_s3;
			logic [AW-1:0]        res_q;
			logic [WORD_W+MW-1:0] prod;
			logic [MW+AW-1:0]     qd;
			logic [WORD_W-1:0]    r_full;

			// quotient estimate is exact or one low, so one subtract corrects it
			assign prod   = x_s1 * RECIP;
			assign qd     = q_s2 * DIV;
			assign r_full = x_s2 - qd[WORD_W-1:0];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s1   <= 1'b0;
					v_s2   <= 1'b0;
					v_s3   <= 1'b0;
					done_q <= 1'b0;
				end else begin
					v_s1   <= start;
					v_s2   <= v_s1;
					v_s3   <= v_s2;
					done_q <= v_s3;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					x_s1 <= val;
				end
				if (v_s1) begin
					q_s2 <= prod[WORD_W+MW-1:WORD_W];
					x_s2 <= x_s1;
				end
				if (v_s2) begin
					r_s3 <= r_full[AW:0];
				end
				if (v_s3) begin
					res_q <= (r_s3 >= DIV_X) ? AW'(r_s3 - DIV_X) : r_s3[AW-1:0];
				end
			end

			assign done = done_q;
			assign res  = res_q;
		end
	endgenerate

endmodule

// File: rtl/core/subleq_dpath.sv
// ---------------------------------------------------------------------------
// subleq_dpath
// Datapath of the subleq core: word memory, program counter, operand and
// scratch registers, step timer, timer period and result registers.
// ---------------------------------------------------------------------------
module subleq_dpath import subleq_pkg::*; #(
	parameter int MEM_DEPTH = DEFAULT_MEM_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output stat_t                    stat,
	input  logic [15:0]              addr,
	input  logic signed [WORD_W-1:0] data,
	input  logic signed [10:0]       key_event,
	input  logic [WORD_W-1:0]        rtc_seconds,
	input  logic [29:0]              rtc_nanoseconds,
	input  logic                     cfg_valid,
	input  logic [PERIOD_W-1:0]      cfg_data,
	output logic signed [WORD_W-1:0] read_data,
	output logic                     serial_valid,
	output logic [7:0]               serial_byte,
	output logic                     halted,
	output logic                     tick_fired,
	output logic [15:0]              next_pc
);

	localparam int AW = $clog2(MEM_DEPTH);

	function automatic logic signed [OPD_W-1:0] quarter(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] t;
		t = w + (w[WORD_W-1] ? 32'd3 : 32'd0);
		return t[WORD_W-1:2];
	endfunction

	logic [WORD_W-1:0] mem [MEM_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic [15:0]             addr_q;
	logic [WORD_W-1:0]       data_q;
	logic [10:0]             key_q;
	logic [WORD_W-1:0]       secs_q;
	logic [29:0]             nsec_q;

	logic [AW-1:0]           pc_q;
	logic [AW-1:0]           clr_q;
	logic signed [OPD_W-1:0] opa_q;
	logic signed [OPD_W-1:0] opb_q;
	logic signed [OPD_W-1:0] opc_q;
	logic [WORD_W-1:0]       tmp_q;
	logic [WORD_W-1:0]       sub_q;
	logic [PERIOD_W-1:0]     timer_q;
	logic [PERIOD_W-1:0]     period_q;

	logic [WORD_W-1:0]       read_data_q;
	logic                    serial_valid_q;
	logic [7:0]              serial_byte_q;
	logic                    halted_q;
	logic                    tick_q;

	logic                    wrap_done;
	logic [AW-1:0]           wrap_res;
	logic [WORD_W-1:0]       wrap_val;
	logic signed [OPD_W-1:0] qrd;
	logic [AW-1:0]           mem_addr;
	logic [WORD_W-1:0]       mem_wdata;
	logic [WORD_W-1:0]       pc_ext;
	logic [PERIOD_W:0]       timer_nxt;

	assign qrd       = quarter(rdata_q);
	assign pc_ext    = WORD_W'(pc_q);
	assign timer_nxt = {1'b0, timer_q} + (PERIOD_W+1)'(1);

	always_comb begin
		case (cmd.wrap_src)
			WSRC_ADDR: wrap_val = WORD_W'(addr_q);
			WSRC_QRD:  wrap_val = {{(WORD_W-OPD_W){qrd[OPD_W-1]}}, qrd};
			WSRC_OPA:  wrap_val = {{(WORD_W-OPD_W){opa_q[OPD_W-1]}}, opa_q};
			WSRC_OPB:  wrap_val = {{(WORD_W-OPD_W){opb_q[OPD_W-1]}}, opb_q};
			WSRC_OPC:  wrap_val = {{(WORD_W-OPD_W){opc_q[OPD_W-1]}}, opc_q};
			default:   wrap_val = '0;
		endcase
	end

	always_comb begin
		case (cmd.addr_sel)
			ASEL_PC:    mem_addr = pc_q;
			ASEL_WRAP:  mem_addr = wrap_res;
			ASEL_CLR:   mem_addr = clr_q;
			ASEL_VEC:   mem_addr = AW'(IRQ_VEC_ADDR);
			ASEL_RET:   mem_addr = AW'(IRQ_RET_ADDR);
			ASEL_RTC_S: mem_addr = AW'(RTC_SEC_ADDR);
			ASEL_RTC_H: mem_addr = AW'(RTC_HI_ADDR);
			ASEL_RTC_N: mem_addr = AW'(RTC_NS_ADDR);
			default:    mem_addr = pc_q;
		endcase
	end

	always_comb begin
		case (cmd.wdata_sel)
			WSEL_ZERO: mem_wdata = '0;
			WSEL_DATA: mem_wdata = data_q;
			WSEL_KEY:  mem_wdata = {{(WORD_W-11){key_q[10]}}, key_q};
			WSEL_SECS: mem_wdata = secs_q;
			WSEL_NSEC: mem_wdata = WORD_W'(nsec_q);
			WSEL_SUB:  mem_wdata = sub_q;
			WSEL_PC4:  mem_wdata = pc_ext << 2;
			default:   mem_wdata = '0;
		endcase
	end

	subleq_wrap #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_wrap (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.wrap_start),
		.val   (wrap_val),
		.done  (wrap_done),
		.res   (wrap_res)
	);

	always_ff @(posedge clk) begin
		if (cmd.mem_en) begin
			if (cmd.mem_we) begin
				mem[mem_addr] <= mem_wdata;
			end else begin
				rdata_q <= mem[mem_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_cap) begin
			addr_q <= addr;
			data_q <= data;
			key_q  <= key_event;
			secs_q <= rtc_seconds;
			nsec_q <= rtc_nanoseconds;
		end
		if (cmd.op_we) begin
			case (cmd.op_sel)
				OP_A:    opa_q <= qrd;
				OP_B:    opb_q <= qrd;
				OP_C:    opc_q <= qrd;
				default: opc_q <= qrd;
			endcase
		end
		if (cmd.tmp_we) begin
			tmp_q <= rdata_q;
		end
		if (cmd.sub_we) begin
			sub_q <= rdata_q - tmp_q;
		end
		if (cmd.set_rd) begin
			read_data_q <= rdata_q;
		end else if (cmd.out_clr) begin
			read_data_q <= '0;
		end
		if (cmd.set_serial) begin
			serial_byte_q <= rdata_q[7:0];
		end else if (cmd.out_clr) begin
			serial_byte_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= '0;
			clr_q          <= '0;
			timer_q        <= '0;
			period_q       <= PERIOD_RESET;
			serial_valid_q <= 1'b0;
			halted_q       <= 1'b0;
			tick_q         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (cmd.clr_inc) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.pc_load) begin
				pc_q <= wrap_res;
			end else if (cmd.pc_inc) begin
				pc_q <= (pc_q == AW'(MEM_DEPTH - 1)) ? '0 : pc_q + AW'(1);
			end
			if (cmd.timer_clr) begin
				timer_q <= '0;
			end else if (cmd.timer_inc) begin
				timer_q <= timer_nxt[PERIOD_W-1:0];
			end
			if (cmd.out_clr) begin
				serial_valid_q <= 1'b0;
				halted_q       <= 1'b0;
				tick_q         <= 1'b0;
			end else begin
				if (cmd.set_serial) begin
					serial_valid_q <= 1'b1;
				end
				if (cmd.set_halt) begin
					halted_q <= 1'b1;
				end
				if (cmd.set_tick) begin
					tick_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		stat.wrap_done = wrap_done;
		stat.raw_ind   = rdata_q[0];
		stat.a_m1      = opa_q == -OPD_W'(1);
		stat.b_m1      = opb_q == -OPD_W'(1);
		stat.a_rtc     = opa_q == OPD_W'(RTC_SEC_ADDR);
		stat.c_zero    = opc_q == '0;
		stat.sub_le0   = sub_q[WORD_W-1] || (sub_q == '0);
		stat.vec_nz    = rdata_q != '0;
		stat.tick_due  = timer_nxt > {1'b0, period_q};
		stat.clr_last  = clr_q == AW'(MEM_DEPTH - 1);
	end

	assign read_data    = read_data_q;
	assign serial_valid = serial_valid_q;
	assign serial_byte  = serial_byte_q;
	assign halted       = halted_q;
	assign tick_fired   = tick_q;
	assign next_pc      = pc_ext[15:0];

endmodule

// File: rtl/core/subleq_ctrl.sv
// ---------------------------------------------------------------------------
// subleq_ctrl
// Controller of the subleq core: sequences the memory clearing pass, host
// loads and reads, and the fetch, decode and execute steps of an instruction.
// ---------------------------------------------------------------------------
module subleq_ctrl import subleq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] func,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy,
	output logic       done
);

	state_t  state_q, state_d;
	func_t   func_q, func_d;
	op_sel_t op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			func_q  <= FN_NONE;
			op_q    <= OP_A;
		end else begin
			state_q <= state_d;
			func_q  <= func_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		func_d  = func_q;
		op_d    = op_q;
		cmd     = '0;
		cmd.op_sel = op_q;

		case (state_q)
			S_CLEAR: begin
				cmd.mem_en    = 1'b1;
				cmd.mem_we    = 1'b1;
				cmd.addr_sel  = ASEL_CLR;
				cmd.wdata_sel = WSEL_ZERO;
				cmd.clr_inc   = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_DONE: begin
				state_d = S_IDLE;
				if (start) begin
					cmd.in_cap  = 1'b1;
					cmd.out_clr = 1'b1;
					func_d      = func_t'(func);
					op_d        = OP_A;
					case (func_t'(func))
						FN_LOAD, FN_READ: state_d = S_HWRAP;
						FN_EXEC:          state_d = S_FETCH;
						default:          state_d = S_DONE;
					endcase
				end
			end
			S_HWRAP: begin
				cmd.wrap_start = 1'b1;
				cmd.wrap_src   = WSRC_ADDR;
				state_d        = S_HWAIT;
			end
			S_HWAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_en    = 1'b1;
					cmd.addr_sel  = ASEL_WRAP;
					cmd.wdata_sel = WSEL_DATA;
					if (func_q == FN_LOAD) begin
						cmd.mem_we = 1'b1;
						state_d    = S_DONE;
					end else begin
						state_d = S_HRD;
					end
				end
			end
			S_HRD: begin
				cmd.set_rd = 1'b1;
				state_d    = S_DONE;
			end
			S_FETCH: begin
				cmd.mem_en   = 1'b1;
				cmd.addr_sel = ASEL_PC;
				cmd.pc_inc   = 1'b1;
				state_d      = S_RAW;
			end
			S_RAW, S_IND: begin
				if (state_q == S_RAW && stat.raw_ind) begin
					cmd.wrap_start = 1'b1;
					cmd.wrap_src   = WSRC_QRD;
					state_d        = S_IWAIT;
				end else begin
					cmd.op_we = 1'b1;
					case (op_q)
						OP_A: begin
							op_d    = OP_B;
							state_d = S_FETCH;
						end
						OP_B: begin
							op_d    = OP_C;
							state_d = S_FETCH;
						end
						default: state_d = S_DEC;
					endcase
				end
			end
			S_IWAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_en   = 1'b1;
					cmd.addr_sel = ASEL_WRAP;
					state_d      = S_IND;
				end
			end
			S_DEC: begin
				cmd.set_halt = stat.c_zero;
				if (stat.a_m1) begin
					cmd.wrap_start = 1'b1;
					cmd.wrap_src   = WSRC_OPB;
					state_d        = S_KWAIT;
				end else if (stat.b_m1) begin
					cmd.wrap_start = 1'b1;
					cmd.wrap_src   = WSRC_OPA;
					state_d        = S_SWAIT;
				end else if (stat.a_rtc) begin
					state_d = S_RTC0;
				end else begin
					state_d = S_AWRAP;
				end
			end
			S_KWAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_en    = 1'b1;
					cmd.mem_we    = 1'b1;
					cmd.addr_sel  = ASEL_WRAP;
					cmd.wdata_sel = WSEL_KEY;
					state_d       = S_DONE;
				end
			end
			S_SWAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_en   = 1'b1;
					cmd.addr_sel = ASEL_WRAP;
					state_d      = S_SER;
				end
			end
			S_SER: begin
				cmd.set_serial = 1'b1;
				state_d        = S_DONE;
			end
			S_RTC0: begin
				cmd.mem_en    = 1'b1;
				cmd.mem_we    = 1'b1;
				cmd.addr_sel  = ASEL_RTC_S;
				cmd.wdata_sel = WSEL_SECS;
				state_d       = S_RTC1;
			end
			S_RTC1: begin
				cmd.mem_en    = 1'b1;
				cmd.mem_we    = 1'b1;
				cmd.addr_sel  = ASEL_RTC_H;
				cmd.wdata_sel = WSEL_ZERO;
				state_d       = S_RTC2;
			end
			S_RTC2: begin
				cmd.mem_en    = 1'b1;
				cmd.mem_we    = 1'b1;
				cmd.addr_sel  = ASEL_RTC_N;
				cmd.wdata_sel = WSEL_NSEC;
				state_d       = S_AWRAP;
			end
			S_AWRAP: begin
				cmd.wrap_start = 1'b1;
				cmd.wrap_src   = WSRC_OPA;
				state_d        = S_AWAIT;
			end
			S_AWAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_en   = 1'b1;
					cmd.addr_sel = ASEL_WRAP;
					state_d      = S_ARD;
				end
			end
			S_ARD: begin
				cmd.tmp_we     = 1'b1;
				cmd.wrap_start = 1'b1;
				cmd.wrap_src   = WSRC_OPB;
				state_d        = S_BWAIT;
			end
			S_BWAIT: begin
				if (stat.wrap_done) begin
					cmd.mem_en   = 1'b1;
					cmd.addr_sel = ASEL_WRAP;
					state_d      = S_BRD;
				end
			end
			S_BRD: begin
				cmd.sub_we = 1'b1;
				state_d    = S_BWR;
			end
			S_BWR: begin
				cmd.mem_en    = 1'b1;
				cmd.mem_we    = 1'b1;
				cmd.addr_sel  = ASEL_WRAP;
				cmd.wdata_sel = WSEL_SUB;
				if (stat.sub_le0) begin
					cmd.wrap_start = 1'b1;
					cmd.wrap_src   = WSRC_OPC;
					state_d        = S_CWAIT;
				end else begin
					state_d = S_M0RD;
				end
			end
			S_CWAIT: begin
				if (stat.wrap_done) begin
					cmd.pc_load = 1'b1;
					state_d     = S_M0RD;
				end
			end
			S_M0RD: begin
				cmd.mem_en   = 1'b1;
				cmd.addr_sel = ASEL_VEC;
				state_d      = S_M0CHK;
			end
			S_M0CHK: begin
				state_d = S_DONE;
				if (stat.vec_nz) begin
					if (stat.tick_due) begin
						cmd.mem_en     = 1'b1;
						cmd.mem_we     = 1'b1;
						cmd.addr_sel   = ASEL_RET;
						cmd.wdata_sel  = WSEL_PC4;
						cmd.timer_clr  = 1'b1;
						cmd.set_tick   = 1'b1;
						cmd.wrap_start = 1'b1;
						cmd.wrap_src   = WSRC_QRD;
						state_d        = S_TWAIT;
					end else begin
						cmd.timer_inc = 1'b1;
					end
				end
			end
			S_TWAIT: begin
				if (stat.wrap_done) begin
					cmd.pc_load = 1'b1;
					state_d     = S_DONE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = !(state_q == S_IDLE || state_q == S_DONE);
	assign done = state_q == S_DONE;

	a_exec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FN_EXEC |=> busy)
		else $error("execute word accepted but core not busy");

	a_wrap_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.wrap_done |-> (state_q == S_HWAIT || state_q == S_IWAIT ||
			state_q == S_KWAIT || state_q == S_SWAIT || state_q == S_AWAIT ||
			state_q == S_BWAIT || state_q == S_CWAIT || state_q == S_TWAIT))
		else $error("address wrap finished outside a wait state");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) && $past(state_q) != S_CLEAR |-> done)
		else $error("word finished without a result strobe");

endmodule

// File: rtl/core/subleq_core_with_mmio.sv
// ---------------------------------------------------------------------------
// subleq_core_with_mmio
// SUBLEQ core with word memory, key, serial, real-time clock and timer
// interrupt mapped into memory.
// ---------------------------------------------------------------------------
// A word is accepted when start is high and busy is low; its result is on
// the result ports for exactly one cycle with done high, and the receiver
// cannot hold it off. After reset the core clears its memory, one word per
// cycle, with busy high; timer period writes are taken at any time. Every
// address taken from the host or from memory goes through a modulo unit, a
// registered mask for a power-of-two depth and a reciprocal multiplication
// otherwise. A subtract instruction goes through the single memory port:
// three operand fetches, up to three indirections, two data reads, the
// result write, the interrupt vector check and any clock or return writes.
module subleq_core_with_mmio import subleq_pkg::*; #(
	parameter int MEM_DEPTH = DEFAULT_MEM_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	output logic                     done,
	input  logic [1:0]               func,
	input  logic [15:0]              addr,
	input  logic signed [WORD_W-1:0] data,
	input  logic signed [10:0]       key_event,
	input  logic [WORD_W-1:0]        rtc_seconds,
	input  logic [29:0]              rtc_nanoseconds,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [PERIOD_W-1:0]      cfg_data,
	output logic signed [WORD_W-1:0] read_data,
	output logic                     serial_valid,
	output logic [7:0]               serial_byte,
	output logic                     halted,
	output logic                     tick_fired,
	output logic [15:0]              next_pc
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	subleq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (func),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	subleq_dpath #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.addr           (addr),
		.data           (data),
		.key_event      (key_event),
		.rtc_seconds    (rtc_seconds),
		.rtc_nanoseconds(rtc_nanoseconds),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.read_data      (read_data),
		.serial_valid   (serial_valid),
		.serial_byte    (serial_byte),
		.halted         (halted),
		.tick_fired     (tick_fired),
		.next_pc        (next_pc)
	);

endmodule

// File: test/tb_subleq_core_with_mmio.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subleq_core_with_mmio
// Drives load, read and execute words into the subleq core and checks every
// result against an in-bench predictor that tracks memory, the program
// counter, the step timer and the timer period. A directed part covers field
// extremes, indirection, key, serial, clock, halt, address wrap and the timer
// interrupt. Random programs with random data then run under several timer
// periods and sender idle rates.
// ----------------------------------------------------------------------------
module tb_subleq_core_with_mmio import subleq_pkg::*;;

	localparam logic [31:0] IO_OPND  = 32'hFFFF_FFFC;
	localparam logic [31:0] RTC_OPND = 32'(RTC_SEC_ADDR * 4);
	localparam logic [31:0] HALT_OPND = 32'd0;

	typedef struct packed {
		logic [31:0] rd;
		logic        sv;
		logic [7:0]  sb;
		logic        hl;
		logic        tf;
		logic [15:0] npc;
	} outcome_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     done;
	logic [1:0]               func;
	logic [15:0]              addr;
	logic signed [WORD_W-1:0] data;
	logic signed [10:0]       key_event;
	logic [WORD_W-1:0]        rtc_seconds;
	logic [29:0]              rtc_nanoseconds;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [PERIOD_W-1:0]      cfg_data;
	logic signed [WORD_W-1:0] read_data;
	logic                     serial_valid;
	logic [7:0]               serial_byte;
	logic                     halted;
	logic                     tick_fired;
	logic [15:0]              next_pc;

	subleq_core_with_mmio dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.func(func),
		.addr(addr),
		.data(data),
		.key_event(key_event),
		.rtc_seconds(rtc_seconds),
		.rtc_nanoseconds(rtc_nanoseconds),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.read_data(read_data),
		.serial_valid(serial_valid),
		.serial_byte(serial_byte),
		.halted(halted),
		.tick_fired(tick_fired),
		.next_pc(next_pc)
	);

	logic [31:0]         mem_img [0:65535];
	logic [15:0]         pc_img;
	logic [23:0]         timer_img;
	logic [PERIOD_W-1:0] period_img;
	outcome_t            outcome_q [$];
	outcome_t            head;
	int                  errors;
	int                  idle_pct;
	int                  sent;
	logic [10:0]         key_now;
	logic [31:0]         secs_now;
	logic [29:0]         ns_now;
	logic [15:0]         prog_base;
	logic [15:0]         dbase;
	logic [15:0]         pbase;
	int                  prog_len;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// byte address to word address, truncating toward zero
	function automatic longint quarter(logic [31:0] w);
		longint v;
		v = longint'($signed(w));
		return v / 4;
	endfunction

	function automatic logic [15:0] wrap16(longint v);
		return 16'(v);
	endfunction

	function automatic longint fetch_operand();
		logic [31:0] raw;
		raw = mem_img[pc_img];
		pc_img = pc_img + 16'd1;
		if (raw[0])
			return quarter(mem_img[wrap16(quarter(raw))]);
		return quarter(raw);
	endfunction

	function automatic outcome_t subleq_exec(func_t fn, logic [15:0] ad, logic [31:0] dt,
			logic [10:0] key, logic [31:0] secs, logic [29:0] ns);
		outcome_t    r;
		longint      a;
		longint      b;
		longint      c;
		logic [15:0] ia;
		logic [15:0] ib;
		logic [24:0] nt;
		r = '0;
		case (fn)
			FN_LOAD: mem_img[ad] = dt;
			FN_READ: r.rd = mem_img[ad];
			FN_EXEC: begin
				a = fetch_operand();
				b = fetch_operand();
				c = fetch_operand();
				if (a == -1) begin
					mem_img[wrap16(b)] = {{21{key[10]}}, key};
				end else if (b == -1) begin
					r.sv = 1'b1;
					r.sb = mem_img[wrap16(a)][7:0];
				end else begin
					if (a == RTC_SEC_ADDR) begin
						mem_img[RTC_SEC_ADDR] = secs;
						mem_img[RTC_HI_ADDR] = '0;
						mem_img[RTC_NS_ADDR] = {2'b00, ns};
					end
					ia = wrap16(a);
					ib = wrap16(b);
					mem_img[ib] = mem_img[ib] - mem_img[ia];
					if ($signed(mem_img[ib]) <= 0)
						pc_img = wrap16(c);
					if (mem_img[IRQ_VEC_ADDR] != 0) begin
						nt = {1'b0, timer_img} + 25'd1;
						if (nt > {1'b0, period_img}) begin
							mem_img[IRQ_RET_ADDR] = {14'd0, pc_img, 2'b00};
							pc_img = wrap16(quarter(mem_img[IRQ_VEC_ADDR]));
							timer_img = '0;
							r.tf = 1'b1;
						end else begin
							timer_img = nt[23:0];
						end
					end
				end
				if (c == 0)
					r.hl = 1'b1;
			end
			default: ;
		endcase
		r.npc = pc_img;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing pending, next_pc expected none got %0h",
					$time, next_pc);
			end else begin
				head = outcome_q.pop_front();
				check_field("read_data", head.rd, read_data);
				check_field("serial_valid", 32'(head.sv), 32'(serial_valid));
				check_field("serial_byte", 32'(head.sb), 32'(serial_byte));
				check_field("halted", 32'(head.hl), 32'(halted));
				check_field("tick_fired", 32'(head.tf), 32'(tick_fired));
				check_field("next_pc", 32'(head.npc), 32'(next_pc));
			end
		end
	end

	task automatic send_word(input func_t fn, input logic [15:0] ad, input logic [31:0] dt);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		func = fn;
		addr = ad;
		data = dt;
		key_event = key_now;
		rtc_seconds = secs_now;
		rtc_nanoseconds = ns_now;
		start = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		outcome_q.push_back(subleq_exec(fn, ad, dt, key_now, secs_now, ns_now));
		sent++;
	endtask

	task automatic load_word(input logic [15:0] ad, input logic [31:0] dt);
		send_word(FN_LOAD, ad, dt);
	endtask

	task automatic read_word(input logic [15:0] ad);
		send_word(FN_READ, ad, $urandom);
	endtask

	task automatic exec_step();
		send_word(FN_EXEC, 16'($urandom), $urandom);
	endtask

	// writes one instruction at the current pc and runs it
	task automatic run_instr(input logic [31:0] oa, input logic [31:0] ob, input logic [31:0] oc);
		logic [15:0] at;
		at = pc_img;
		load_word(at, oa);
		load_word(at + 16'd1, ob);
		load_word(at + 16'd2, oc);
		exec_step();
	endtask

	task automatic shuffle_sensors();
		key_now = 11'($urandom_range(2046) - 1023);
		secs_now = $urandom;
		ns_now = 30'($urandom_range(999999999));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] v);
		wait_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		period_img = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3, 4: return 32'($urandom_range(16)) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] data_opnd();
		return {14'd0, dbase + 16'($urandom_range(3)), 2'b00};
	endfunction

	function automatic logic [31:0] pick_src();
		case ($urandom_range(13))
			0: return IO_OPND;
			1: return IO_OPND - 32'd2;
			2: return RTC_OPND;
			3: return RTC_OPND + 32'd2;
			4, 5: return {14'd0, pbase + 16'($urandom_range(1)), 2'b01};
			6: return $urandom;
			default: return data_opnd();
		endcase
	endfunction

	function automatic logic [31:0] pick_dst();
		case ($urandom_range(13))
			0: return IO_OPND;
			1: return $urandom;
			2: return {14'd0, pbase + 16'($urandom_range(1)), 2'b01};
			default: return data_opnd();
		endcase
	endfunction

	function automatic logic [31:0] pick_target();
		case ($urandom_range(11))
			0: return HALT_OPND;
			1: return 32'hFFFF_FFFE;
			2: return $urandom;
			default: return {14'd0, prog_base + 16'(3 * $urandom_range(prog_len - 1)), 2'b00};
		endcase
	endfunction

	task automatic test_load_read();
		load_word(16'd0, 32'h8000_0000);
		load_word(16'hFFFF, 32'h7FFF_FFFF);
		read_word(16'd0);
		read_word(16'hFFFF);
		read_word(16'h5A5A);
		send_word(FN_NONE, 16'hFFFF, 32'hFFFF_FFFF);
		load_word(16'd0, 32'd0);
	endtask

	task automatic test_subtract();
		load_word(16'd200, 32'd5);
		load_word(16'd201, 32'd3);
		load_word(16'd202, 32'd800);
		run_instr(32'd800, 32'd804, 32'd1200);
		run_instr(32'd804, 32'd800, HALT_OPND);
		run_instr(32'd809, 32'd804, 32'd1600);
		read_word(16'd201);
	endtask

	task automatic test_devices();
		key_now = 11'sd1023;
		run_instr(IO_OPND, 32'd812, 32'd1600);
		key_now = -11'sd1023;
		run_instr(IO_OPND - 32'd2, 32'd816, HALT_OPND);
		key_now = -11'sd5;
		run_instr(IO_OPND, IO_OPND, 32'd1600);
		run_instr(32'd816, IO_OPND, HALT_OPND);
		secs_now = 32'hFFFF_FFFF;
		ns_now = 30'd999999999;
		run_instr(RTC_OPND, 32'd820, 32'd1600);
		read_word(16'(RTC_NS_ADDR));
		secs_now = '0;
		ns_now = '0;
		run_instr(RTC_OPND, 32'd820, 32'd1600);
		read_word(16'(RTC_SEC_ADDR));
	endtask

	task automatic test_timer_and_wrap();
		write_period('0);
		load_word(16'(IRQ_VEC_ADDR), 32'd1600);
		run_instr(32'd800, 32'd804, 32'd2000);
		read_word(16'(IRQ_RET_ADDR));
		load_word(16'(IRQ_VEC_ADDR), 32'd0);
		run_instr(32'd824, 32'd824, {14'd0, 16'hFFFF, 2'b00});
		run_instr(32'd800, 32'd804, 32'd2000);
	endtask

	task automatic run_program();
		int k;
		shuffle_sensors();
		prog_base = 16'($urandom);
		prog_len = $urandom_range(3, 6);
		dbase = prog_base + 16'd24;
		pbase = prog_base + 16'd32;
		if ($urandom_range(2) == 0)
			load_word(16'(IRQ_VEC_ADDR), $urandom_range(1) ? {14'd0, prog_base, 2'b00} : 32'd0);
		run_instr({14'd0, dbase, 2'b00}, {14'd0, dbase, 2'b00}, {14'd0, prog_base, 2'b00});
		for (k = 0; k < 4; k++)
			load_word(dbase + 16'(k), rand_value());
		for (k = 0; k < 2; k++)
			load_word(pbase + 16'(k), $urandom_range(5) == 0 ? IO_OPND : data_opnd());
		for (k = 0; k < prog_len; k++) begin
			load_word(prog_base + 16'(3 * k), pick_src());
			load_word(prog_base + 16'(3 * k + 1), pick_dst());
			load_word(prog_base + 16'(3 * k + 2), pick_target());
		end
		repeat (3 * prog_len) begin
			shuffle_sensors();
			exec_step();
		end
	endtask

	task automatic test_random(input int pct, input logic [PERIOD_W-1:0] period, input int quota);
		int first;
		int pick;
		write_period(period);
		idle_pct = pct;
		first = sent;
		while (sent - first < quota) begin
			pick = $urandom_range(19);
			shuffle_sensors();
			if (pick < 11)
				run_program();
			else if (pick < 15)
				run_instr(pick_src(), pick_dst(), pick_target());
			else if (pick < 17)
				read_word($urandom_range(1) ? 16'($urandom) : dbase + 16'($urandom_range(3)));
			else if (pick == 17)
				load_word(16'($urandom), rand_value());
			else if (pick == 18)
				send_word($urandom_range(1) ? FN_NONE : FN_EXEC, 16'($urandom), $urandom);
			else
				wait_idle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		func = FN_LOAD;
		addr = '0;
		data = '0;
		key_event = '0;
		rtc_seconds = '0;
		rtc_nanoseconds = '0;
		foreach (mem_img[i])
			mem_img[i] = '0;
		pc_img = '0;
		timer_img = '0;
		period_img = PERIOD_RESET;
		errors = 0;
		idle_pct = 0;
		sent = 0;
		prog_base = 16'd256;
		prog_len = 3;
		dbase = 16'd280;
		pbase = 16'd288;
		shuffle_sensors();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_load_read();
		test_subtract();
		test_devices();
		test_timer_and_wrap();
		test_random(0, 24'hFFFFFF, 175);
		test_random(62, 24'd3, 175);
		test_random(23, 24'd0, 175);
		test_random(0, 24'd40, 175);

		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb_subleq_core_with_mmio OK");
		else
			$display("tb_subleq_core_with_mmio NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_subleq_core_with_mmio NOT OK");
		$finish;
	end

endmodule

// File: files.f
rtl/core/subleq_pkg.sv
rtl/core/subleq_wrap.sv
rtl/core/subleq_dpath.sv
rtl/core/subleq_ctrl.sv
rtl/core/subleq_core_with_mmio.sv
test/tb_subleq_core_with_mmio.sv
